[hw/rtl/fkw_pkg.sv]
package fkw_pkg;

   localparam logic [31:0] SEED_BASE   = 32'd123456789;
   localparam logic [30:0] PM_MOD      = 31'h7fff_ffff;
   localparam logic [14:0] PM_MULT     = 15'd16807;
   localparam logic [30:0] HALF_DRAW   = 31'h4000_0000;
   localparam logic [63:0] ONE_Q30     = 64'h0000_0000_4000_0000;
   localparam logic [63:0] SLIM        = 64'h4000_0000_0000_0000;
   localparam int          QUEUE_DEPTH = 2;

   localparam logic [31:0] RST_INV_A_SQ  = 32'd268435456;
   localparam logic [31:0] RST_INV_B_SQ  = 32'd1073741824;
   localparam logic [31:0] RST_TIME_STEP = 32'd1073742;
   localparam logic [31:0] RST_STEP_SIZE = 32'd48019194;
   localparam logic [23:0] RST_MAX_STEPS = 24'd1000000;

   typedef enum logic [2:0] {
      CSR_INV_A_SQ,
      CSR_INV_B_SQ,
      CSR_TIME_STEP,
      CSR_STEP_SIZE,
      CSR_MAX_STEPS
   } csr_idx_type;

   typedef enum logic [1:0] {
      SH_26,
      SH_28,
      SH_30,
      SH_31
   } shift_type;

   typedef enum logic [1:0] {
      MV_NONE,
      MV_PLUS,
      MV_MINUS
   } move_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POT,
      S_POT_SUM,
      S_POT_FIN,
      S_CHECK,
      S_DRAW,
      S_MOVE,
      S_WGT,
      S_OUTS,
      S_OUTS_CMP,
      S_PUSH
   } walk_state_type;

   typedef struct packed {
      logic [31:0] inv_a_sq;
      logic [31:0] inv_b_sq;
      logic [31:0] time_step;
      logic [31:0] step_size;
      logic [23:0] max_steps;
   } cfg_type;

   typedef struct packed {
      logic        start;
      shift_type   shift;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } mul_rsp_type;

endpackage

[hw/rtl/fkw_fifo.sv]
module fkw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[hw/rtl/fkw_front.sv]
module fkw_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                     req_push,
   output logic                     req_full,
   input  logic signed [31:0]       req_start_x,
   input  logic signed [31:0]       req_start_y,
   input  logic [29:0]              req_trial_index,
   input  logic                     job_full,
   output logic                     job_push,
   output logic [2*COORD_WIDTH+30:0] job_data
);
   import fkw_pkg::*;

   localparam logic signed [65:0] CMAX = (66'sd1 <<< (COORD_WIDTH - 1)) - 66'sd1;
   localparam logic signed [65:0] CMIN = -CMAX - 66'sd1;

   logic signed [COORD_WIDTH-1:0] x_sat, y_sat;
   logic [31:0]                   seed_sum;

   function automatic logic signed [COORD_WIDTH-1:0] sat_start(logic signed [31:0] v);
      logic signed [65:0] ve;
      ve = 66'(v);
      if (ve > CMAX) return COORD_WIDTH'(CMAX);
      if (ve < CMIN) return COORD_WIDTH'(CMIN);
      return COORD_WIDTH'(ve);
   endfunction

   assign x_sat    = sat_start(req_start_x);
   assign y_sat    = sat_start(req_start_y);
   // seed stays below 2^31 - 1 for every index
   assign seed_sum = SEED_BASE + 32'(req_trial_index);

   assign req_full = job_full;
   assign job_push = req_push & ~job_full;
   assign job_data = {x_sat, y_sat, seed_sum[30:0]};

endmodule

[hw/rtl/fkw_mul.sv]
module fkw_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  fkw_pkg::mul_req_type mul_req,
   output fkw_pkg::mul_rsp_type mul_rsp
);
   import fkw_pkg::*;

   // 64x64 -> 128 over four 32x32 partial products, then shift and saturate
   logic          busy_ff, busy_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [63:0]   a_ff, a_in, b_ff, b_in;
   shift_type     sh_ff, sh_in;
   logic [63:0]   pp_ff, pp_in;
   logic [127:0]  acc_ff, acc_in;
   logic          done_ff, done_in;
   logic [63:0]   res_ff, res_in;
   logic [31:0]   a_half, b_half;
   logic [2:0]    lane;
   logic [1:0]    pos;
   logic          ovf;
   logic [63:0]   val;

   assign a_half = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_half = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign lane   = cnt_ff - 3'd1;
   assign pos    = 2'(lane[1]) + 2'(lane[0]);

   always_comb begin
      case (sh_ff)
         SH_26: begin
            ovf = |acc_ff[127:90];
            val = acc_ff[89:26];
         end
         SH_28: begin
            ovf = |acc_ff[127:92];
            val = acc_ff[91:28];
         end
         SH_30: begin
            ovf = |acc_ff[127:94];
            val = acc_ff[93:30];
         end
         default: begin
            ovf = |acc_ff[127:95];
            val = acc_ff[94:31];
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      sh_in   = sh_ff;
      pp_in   = pp_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (!busy_ff) begin
         if (mul_req.start) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            a_in    = mul_req.a;
            b_in    = mul_req.b;
            sh_in   = mul_req.shift;
            acc_in  = '0;
         end
      end else begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff <= 3'd3) begin
            pp_in = a_half * b_half;
         end
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
            case (pos)
               2'd0:    acc_in = acc_ff + {64'd0, pp_ff};
               2'd1:    acc_in = acc_ff + {32'd0, pp_ff, 32'd0};
               default: acc_in = acc_ff + {pp_ff, 64'd0};
            endcase
         end
         if (cnt_ff == 3'd5) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = ovf ? '1 : val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      sh_ff  <= sh_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign mul_rsp.done  = done_ff;
   assign mul_rsp.value = res_ff;

endmodule

[hw/rtl/fkw_walk.sv]
module fkw_walk #(
   parameter int COORD_WIDTH      = 32,
   parameter int STEP_COUNT_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fkw_pkg::cfg_type              cfg,
   input  logic                          job_empty,
   output logic                          job_pop,
   input  logic signed [COORD_WIDTH-1:0] job_x,
   input  logic signed [COORD_WIDTH-1:0] job_y,
   input  logic [30:0]                   job_seed,
   input  logic                          res_full,
   output logic                          res_push,
   output logic signed [31:0]            res_weight,
   output logic [23:0]                   res_steps,
   output logic                          res_hit
);
   import fkw_pkg::*;

   localparam logic signed [65:0] CMAX = (66'sd1 <<< (COORD_WIDTH - 1)) - 66'sd1;
   localparam logic signed [65:0] CMIN = -CMAX - 66'sd1;
   localparam logic [32:0] CNT_MAX = (33'd1 << STEP_COUNT_WIDTH) - 33'd1;
   localparam logic signed [64:0] SLIM65 = 65'sh0_4000_0000_0000_0000;
   localparam logic signed [64:0] WMAX65 = 65'sh0_0000_0000_7fff_ffff;
   localparam logic signed [64:0] WMIN65 = -WMAX65 - 65'sd1;

   walk_state_type                state_ff, state_in;
   logic [2:0]                    uop_ff, uop_in;
   logic                          pend_ff, pend_in;
   logic                          init_ff, init_in;
   logic                          hit_ff, hit_in;
   logic signed [COORD_WIDTH-1:0] x_ff, x_in, y_ff, y_in;
   logic [30:0]                   seed_ff, seed_in;
   logic [STEP_COUNT_WIDTH-1:0]   n_ff, n_in;
   logic signed [31:0]            w_ff, w_in;
   logic [62:0]                   vs_ff, vs_in, vh_ff, vh_in;
   logic [63:0]                   t0_ff, t0_in, t1_ff, t1_in;
   logic [64:0]                   sum_ff, sum_in;
   logic signed [63:0]            f_ff, f_in, we_ff, we_in, p1_ff, p1_in;
   move_type                      mvx_ff, mvx_in, mvy_ff, mvy_in;

   mul_req_type        mreq;
   mul_rsp_type        mrsp;
   logic               mul_state, got, neg, below, at_limit, outside;
   logic [30:0]        pm_val;
   logic [63:0]        mag_x, mag_y, mag_w, mag_f, mag_we, h64;
   logic [62:0]        prod_c, pot_val;
   logic signed [63:0] prod_s, sum_sat;
   logic [31:0]        limit;
   logic signed [65:0] dstep, x_sum, y_sum;
   logic [66:0]        pot_tot;
   logic signed [64:0] pq_sum, w_diff;
   logic signed [31:0] w_sat;

   function automatic logic [63:0] mag65(logic signed [64:0] v);
      return v[64] ? 64'(-v) : 64'(v);
   endfunction

   // Park-Miller step, 16807 * s mod (2^31 - 1)
   function automatic logic [30:0] pm_next(logic [30:0] s);
      logic [45:0] p;
      logic [31:0] r;
      p = s * PM_MULT;
      r = 32'(p[30:0]) + 32'(p[45:31]);
      if (r >= 32'(PM_MOD)) r = r - 32'(PM_MOD);
      return r[30:0];
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(logic signed [65:0] v);
      if (v > CMAX) return COORD_WIDTH'(CMAX);
      if (v < CMIN) return COORD_WIDTH'(CMIN);
      return COORD_WIDTH'(v);
   endfunction

   fkw_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mreq),
      .mul_rsp (mrsp)
   );

   assign mul_state = (state_ff == S_POT) || (state_ff == S_OUTS) || (state_ff == S_WGT);
   assign got       = pend_ff & mrsp.done;

   assign mag_x  = mag65(65'(x_ff));
   assign mag_y  = mag65(65'(y_ff));
   assign mag_w  = mag65(65'(w_ff));
   assign mag_f  = mag65(65'(f_ff));
   assign mag_we = mag65(65'(we_ff));
   assign h64    = 64'(cfg.time_step);

   assign pm_val = pm_next(seed_ff);
   assign below  = (pm_val < HALF_DRAW);

   assign limit    = (33'(cfg.max_steps) > CNT_MAX) ? CNT_MAX[31:0] : 32'(cfg.max_steps);
   assign at_limit = (32'(n_ff) >= limit);

   assign dstep = 66'(cfg.step_size[31:2]);
   always_comb begin
      case (mvx_ff)
         MV_PLUS:  x_sum = 66'(x_ff) + dstep;
         MV_MINUS: x_sum = 66'(x_ff) - dstep;
         default:  x_sum = 66'(x_ff);
      endcase
      case (mvy_ff)
         MV_PLUS:  y_sum = 66'(y_ff) + dstep;
         MV_MINUS: y_sum = 66'(y_ff) - dstep;
         default:  y_sum = 66'(y_ff);
      endcase
   end

   // 2*(ux^2 + uy^2) + 1/a^2 + 1/b^2, capped at 2^62
   assign pot_tot = 67'({sum_ff, 1'b0}) + 67'(cfg.inv_a_sq) + 67'(cfg.inv_b_sq);
   assign pot_val = (pot_tot >= 67'(SLIM)) ? SLIM[62:0] : pot_tot[62:0];
   assign outside = ((65'(t0_ff) + 65'(t1_ff)) >= 65'(ONE_Q30));

   // signed product: magnitude capped at 2^62, sign applied after
   assign prod_c = (mrsp.value > SLIM) ? SLIM[62:0] : mrsp.value[62:0];
   assign prod_s = neg ? -$signed(64'(prod_c)) : $signed(64'(prod_c));

   assign pq_sum  = 65'(p1_ff) + 65'(prod_s);
   assign sum_sat = (pq_sum > SLIM65) ? 64'(SLIM65) :
                    (pq_sum < -SLIM65) ? 64'(-SLIM65) : 64'(pq_sum);
   assign w_diff  = 65'(w_ff) - 65'(prod_s);
   assign w_sat   = (w_diff > WMAX65) ? 32'(WMAX65) :
                    (w_diff < WMIN65) ? 32'(WMIN65) : 32'(w_diff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (!job_empty) state_in = S_POT;
         S_POT:      if (got && uop_ff == 3'd3) state_in = S_POT_SUM;
         S_POT_SUM:  state_in = S_POT_FIN;
         S_POT_FIN:  state_in = init_ff ? S_CHECK : S_WGT;
         S_CHECK:    state_in = at_limit ? S_PUSH : S_DRAW;
         S_DRAW: begin
            if ((uop_ff == 3'd2 && !below) || uop_ff == 3'd3) state_in = S_MOVE;
         end
         S_MOVE:     state_in = S_POT;
         S_WGT:      if (got && uop_ff == 3'd4) state_in = S_OUTS;
         S_OUTS:     if (got && uop_ff == 3'd3) state_in = S_OUTS_CMP;
         S_OUTS_CMP: state_in = outside ? S_PUSH : S_CHECK;
         S_PUSH:     if (!res_full) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs and multiplier operands
   always_comb begin
      job_pop    = (state_ff == S_IDLE) && !job_empty;
      res_push   = (state_ff == S_PUSH) && !res_full;
      mreq.start = mul_state && !pend_ff;
      mreq.shift = SH_30;
      mreq.a     = '0;
      mreq.b     = '0;
      neg        = 1'b0;
      case (state_ff)
         S_POT: begin
            case (uop_ff)
               3'd0: begin
                  mreq.a = mag_x;  mreq.b = 64'(cfg.inv_a_sq); mreq.shift = SH_28;
               end
               3'd1: begin
                  mreq.a = t0_ff;  mreq.b = t0_ff;
               end
               3'd2: begin
                  mreq.a = mag_y;  mreq.b = 64'(cfg.inv_b_sq); mreq.shift = SH_28;
               end
               default: begin
                  mreq.a = t1_ff;  mreq.b = t1_ff;
               end
            endcase
         end
         S_OUTS: begin
            case (uop_ff)
               3'd0: begin
                  mreq.a = mag_x;  mreq.b = mag_x; mreq.shift = SH_26;
               end
               3'd1: begin
                  mreq.a = t0_ff;  mreq.b = 64'(cfg.inv_a_sq);
               end
               3'd2: begin
                  mreq.a = mag_y;  mreq.b = mag_y; mreq.shift = SH_26;
               end
               default: begin
                  mreq.a = t1_ff;  mreq.b = 64'(cfg.inv_b_sq);
               end
            endcase
         end
         S_WGT: begin
            case (uop_ff)
               3'd0: begin
                  mreq.a = h64;         mreq.b = 64'(vs_ff);
               end
               3'd1: begin
                  mreq.a = mag_f;       mreq.b = mag_w;  neg = f_ff[63] ^ w_ff[31];
               end
               3'd2: begin
                  mreq.a = 64'(vh_ff);  mreq.b = mag_we; neg = we_ff[63];
               end
               3'd3: begin
                  mreq.a = 64'(vs_ff);  mreq.b = mag_w;  neg = w_ff[31];
               end
               default: begin
                  // f holds the clamped trapezoid sum here
                  mreq.a = h64;         mreq.b = mag_f;  neg = f_ff[63];
                  mreq.shift = SH_31;
               end
            endcase
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      uop_in  = uop_ff;
      pend_in = pend_ff;
      init_in = init_ff;
      hit_in  = hit_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      seed_in = seed_ff;
      n_in    = n_ff;
      w_in    = w_ff;
      vs_in   = vs_ff;
      vh_in   = vh_ff;
      t0_in   = t0_ff;
      t1_in   = t1_ff;
      sum_in  = sum_ff;
      f_in    = f_ff;
      we_in   = we_ff;
      p1_in   = p1_ff;
      mvx_in  = mvx_ff;
      mvy_in  = mvy_ff;

      if (mul_state) begin
         if (!pend_ff) begin
            pend_in = 1'b1;
         end else if (mrsp.done) begin
            pend_in = 1'b0;
            uop_in  = uop_ff + 3'd1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               x_in    = job_x;
               y_in    = job_y;
               seed_in = job_seed;
               n_in    = '0;
               w_in    = 32'(ONE_Q30);
               init_in = 1'b1;
               hit_in  = 1'b0;
               uop_in  = '0;
               pend_in = 1'b0;
            end
         end
         S_POT: begin
            if (got) begin
               if (uop_ff <= 3'd1) t0_in = mrsp.value;
               else                t1_in = mrsp.value;
               if (uop_ff == 3'd3) uop_in = '0;
            end
         end
         S_POT_SUM: sum_in = 65'(t0_ff) + 65'(t1_ff);
         S_POT_FIN: begin
            if (init_ff) begin
               vs_in   = pot_val;
               init_in = 1'b0;
            end else begin
               vh_in = pot_val;
            end
         end
         S_CHECK: begin
            if (at_limit) hit_in = 1'b1;
            uop_in = '0;
         end
         S_DRAW: begin
            seed_in = pm_val;
            case (uop_ff)
               3'd0: begin
                  if (below) uop_in = 3'd1;
                  else begin
                     mvx_in = MV_NONE;
                     uop_in = 3'd2;
                  end
               end
               3'd1: begin
                  mvx_in = below ? MV_MINUS : MV_PLUS;
                  uop_in = 3'd2;
               end
               3'd2: begin
                  if (below) uop_in = 3'd3;
                  else begin
                     mvy_in = MV_NONE;
                     uop_in = '0;
                  end
               end
               default: begin
                  mvy_in = below ? MV_MINUS : MV_PLUS;
                  uop_in = '0;
               end
            endcase
         end
         S_MOVE: begin
            x_in   = sat_coord(x_sum);
            y_in   = sat_coord(y_sum);
            uop_in = '0;
         end
         S_WGT: begin
            if (got) begin
               case (uop_ff)
                  3'd0: f_in  = $signed(ONE_Q30) - prod_s;
                  3'd1: we_in = prod_s;
                  3'd2: p1_in = prod_s;
                  3'd3: f_in  = sum_sat;
                  default: begin
                     w_in   = w_sat;
                     n_in   = n_ff + 1'b1;
                     uop_in = '0;
                  end
               endcase
            end
         end
         S_OUTS: begin
            if (got) begin
               if (uop_ff <= 3'd1) t0_in = mrsp.value;
               else                t1_in = mrsp.value;
               if (uop_ff == 3'd3) uop_in = '0;
            end
         end
         S_OUTS_CMP: begin
            if (!outside) vs_in = vh_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         uop_ff   <= '0;
         pend_ff  <= 1'b0;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         uop_ff   <= uop_in;
         pend_ff  <= pend_in;
         init_ff  <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= hit_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      seed_ff <= seed_in;
      n_ff    <= n_in;
      w_ff    <= w_in;
      vs_ff   <= vs_in;
      vh_ff   <= vh_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      sum_ff  <= sum_in;
      f_ff    <= f_in;
      we_ff   <= we_in;
      p1_ff   <= p1_in;
      mvx_ff  <= mvx_in;
      mvy_ff  <= mvy_in;
   end

   assign res_weight = w_ff;
   assign res_steps  = 24'(32'(n_ff));
   assign res_hit    = hit_ff;

endmodule

[hw/rtl/feynman_kac_walk_trial.sv]
// channel | direction | handshake        | payload
// req     | in        | req_push/req_full | start_x, start_y (Q4.28), trial_index
// rsp     | out       | rsp_pop/rsp_empty | weight (Q2.30), steps_taken, limit_hit
// csr     | in        | csr_wr_en         | csr_index, csr_wdata
//
// One request at a time in the walk engine; a two-entry queue sits on each side.
// Each walk step shares the single 32x32 multiplier over 13 products.
// Reset empties both queues and returns the engine to idle; registers take defaults.
// A full response queue holds the engine; requests still queue while it walks.
module feynman_kac_walk_trial #(
   parameter int COORD_WIDTH      = 32,
   parameter int STEP_COUNT_WIDTH = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic [29:0]        req_trial_index,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_weight,
   output logic [23:0]        rsp_steps_taken,
   output logic               rsp_limit_hit,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import fkw_pkg::*;

   localparam int JOB_W = 2 * COORD_WIDTH + 31;
   localparam int RSP_W = 32 + 24 + 1;

   cfg_type                       cfg_ff, cfg_in;
   logic                          job_push, job_full, job_pop, job_empty;
   logic [JOB_W-1:0]              job_wdata, job_rdata;
   logic signed [COORD_WIDTH-1:0] job_x, job_y;
   logic [30:0]                   job_seed;
   logic                          res_push, res_full, res_hit;
   logic signed [31:0]            res_weight;
   logic [23:0]                   res_steps;
   logic [RSP_W-1:0]              rsp_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_INV_A_SQ:  cfg_in.inv_a_sq  = csr_wdata;
            CSR_INV_B_SQ:  cfg_in.inv_b_sq  = csr_wdata;
            CSR_TIME_STEP: cfg_in.time_step = csr_wdata;
            CSR_STEP_SIZE: cfg_in.step_size = csr_wdata;
            CSR_MAX_STEPS: cfg_in.max_steps = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_a_sq  <= RST_INV_A_SQ;
         cfg_ff.inv_b_sq  <= RST_INV_B_SQ;
         cfg_ff.time_step <= RST_TIME_STEP;
         cfg_ff.step_size <= RST_STEP_SIZE;
         cfg_ff.max_steps <= RST_MAX_STEPS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fkw_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .req_push        (req_push),
      .req_full        (req_full),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_trial_index (req_trial_index),
      .job_full        (job_full),
      .job_push        (job_push),
      .job_data        (job_wdata)
   );

   fkw_fifo #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_job_q (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .full  (job_full),
      .wdata (job_wdata),
      .pop   (job_pop),
      .empty (job_empty),
      .rdata (job_rdata)
   );

   assign {job_x, job_y, job_seed} = job_rdata;

   fkw_walk #(
      .COORD_WIDTH      (COORD_WIDTH),
      .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_empty  (job_empty),
      .job_pop    (job_pop),
      .job_x      (job_x),
      .job_y      (job_y),
      .job_seed   (job_seed),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_weight (res_weight),
      .res_steps  (res_steps),
      .res_hit    (res_hit)
   );

   fkw_fifo #(.WIDTH(RSP_W), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .full  (res_full),
      .wdata ({res_weight, res_steps, res_hit}),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rsp_rdata)
   );

   assign {rsp_weight, rsp_steps_taken, rsp_limit_hit} = rsp_rdata;

   a_job_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_empty)
      else $error("job queue popped while empty");

   a_res_push_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("response pushed into full queue");

   a_limit_steps: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_limit_hit) |-> (rsp_steps_taken <= cfg_ff.max_steps))
      else $error("limit response beyond step limit");

   a_exit_steps: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_limit_hit) |-> (rsp_steps_taken != 24'd0))
      else $error("exit response without a step");

endmodule

[tb/sv/feynman_kac_walk_trial_tb.sv]
module feynman_kac_walk_trial_tb;
   import fkw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          IDLE_LIMIT = 4000000;
   localparam logic [2:0]  CSR_SPARE  = 3'd5;
   localparam logic [2:0]  CSR_TOP    = 3'd7;
   localparam logic [63:0] ALL_ONES   = 64'hffff_ffff_ffff_ffff;
   localparam longint      COORD_HI   = 64'sd2147483647;
   localparam longint      COORD_LO   = -64'sd2147483648;
   localparam longint      W_HI       = 64'sd2147483647;
   localparam longint      W_LO       = -64'sd2147483648;

   typedef struct {
      logic signed [31:0] weight;
      logic [23:0]        steps;
      logic               hit;
   } walk_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic signed [31:0] req_start_x = '0;
   logic signed [31:0] req_start_y = '0;
   logic [29:0]        req_trial_index = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [31:0] rsp_weight;
   logic [23:0]        rsp_steps_taken;
   logic               rsp_limit_hit;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   // shadow registers
   logic [63:0] m_inv_a, m_inv_b, m_h, m_step, m_max;

   walk_out_type pending_walks[$];
   int        errors = 0;
   int        idle_cycles = 0;
   int        pop_wait = 0;
   bit        calm = 1'b0;

   feynman_kac_walk_trial u_dut (.*);

   always #5 clock = ~clock;

   function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] p;
      p = ({64'b0, a} * {64'b0, b}) >> s;
      if (p[127:64] != 0) return ALL_ONES;
      return p[63:0];
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[64] ? ALL_ONES : t[63:0];
   endfunction

   function automatic logic [63:0] absval(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint lim_u(logic [63:0] m);
      return (m > SLIM) ? longint'(SLIM) : longint'(m);
   endfunction

   function automatic longint lim_s(longint v);
      if (v > longint'(SLIM)) return longint'(SLIM);
      if (v < -longint'(SLIM)) return -longint'(SLIM);
      return v;
   endfunction

   function automatic longint smulq(longint a, longint b, int s);
      longint p;
      p = lim_u(mulq(absval(a), absval(b), s));
      return ((a < 0) != (b < 0)) ? -p : p;
   endfunction

   function automatic longint coord_step(longint x, longint d);
      if (d > 0 && x > COORD_HI - d) return COORD_HI;
      if (d < 0 && x < COORD_LO - d) return COORD_LO;
      return x + d;
   endfunction

   function automatic longint potential(longint x, longint y);
      logic [63:0] ux, uy, s;
      ux = mulq(absval(x), m_inv_a, 28);
      uy = mulq(absval(y), m_inv_b, 28);
      s = add_sat(mulq(ux, ux, 30), mulq(uy, uy, 30));
      s = add_sat(s, s);
      s = add_sat(add_sat(s, m_inv_a), m_inv_b);
      return lim_u(s);
   endfunction

   function automatic bit off_ellipse(longint x, longint y);
      logic [63:0] mx, my, c;
      mx = absval(x);
      my = absval(y);
      c = add_sat(mulq(mulq(mx, mx, 26), m_inv_a, 30), mulq(mulq(my, my, 26), m_inv_b, 30));
      return c >= ONE_Q30;
   endfunction

   function automatic longint park_miller(longint v);
      longint k;
      k = v / 127773;
      v = 16807 * (v - k * 127773) - k * 2836;
      if (v < 0) v += 2147483647;
      return v;
   endfunction

   function automatic longint pick_move(ref longint seed, input longint d);
      seed = park_miller(seed);
      if (seed >= longint'(HALF_DRAW)) return 0;
      seed = park_miller(seed);
      return (seed < longint'(HALF_DRAW)) ? -d : d;
   endfunction

   function automatic walk_out_type walk(logic signed [31:0] sx, logic signed [31:0] sy,
                                         logic [29:0] idx);
      walk_out_type r;
      longint      seed, x, y, d, h, w, dx, dy, vs, vh, f, we, sum;
      logic [63:0] n;
      bit          hit;
      seed = longint'(SEED_BASE) + longint'(idx);
      x = sx;
      y = sy;
      d = longint'(m_step >> 2);
      h = longint'(m_h);
      w = longint'(ONE_Q30);
      n = 0;
      hit = 0;
      forever begin
         if (n >= m_max) begin
            hit = 1;
            break;
         end
         dx = pick_move(seed, d);
         dy = pick_move(seed, d);
         vs = potential(x, y);
         x = coord_step(x, dx);
         y = coord_step(y, dy);
         vh = potential(x, y);
         f = lim_s(longint'(ONE_Q30) - smulq(h, vs, 30));
         we = smulq(f, w, 30);
         sum = lim_s(smulq(vh, we, 30) + smulq(vs, w, 30));
         w = lim_s(w - smulq(h, sum, 31));
         if (w > W_HI) w = W_HI;
         if (w < W_LO) w = W_LO;
         n++;
         if (off_ellipse(x, y)) break;
      end
      r.weight = w[31:0];
      r.steps = n[23:0];
      r.hit = hit;
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      req_push = 1'b0;
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_INV_A_SQ:  m_inv_a = val;
         CSR_INV_B_SQ:  m_inv_b = val;
         CSR_TIME_STEP: m_h = val;
         CSR_STEP_SIZE: m_step = val;
         CSR_MAX_STEPS: m_max = val[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic send_trial(logic signed [31:0] sx, logic signed [31:0] sy, logic [29:0] idx);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push = 1'b1;
      req_start_x = sx;
      req_start_y = sy;
      req_trial_index = idx;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      pending_walks.push_back(walk(sx, sy, idx));
   endtask

   task automatic drain;
      @(negedge clock);
      req_push = 1'b0;
      wait (pending_walks.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic test_defaults;
      send_trial(32'sd0, 32'sd0, 30'd0);
      send_trial(32'sd134217728, -32'sd67108864, 30'd1000000000);
      drain();
   endtask

   task automatic test_edges;
      // big moves on a tiny ellipse: every walk exits within a few steps
      csr_write(CSR_INV_A_SQ, 32'hffff_ffff);
      csr_write(CSR_INV_B_SQ, 32'hffff_ffff);
      csr_write(CSR_TIME_STEP, 32'hffff_ffff);
      csr_write(CSR_STEP_SIZE, 32'hffff_ffff);
      csr_write(CSR_MAX_STEPS, 32'h00ff_ffff);
      send_trial(32'sh7fff_ffff, 32'sh7fff_ffff, 30'd7);
      send_trial(-32'sh8000_0000, -32'sh8000_0000, 30'd8);
      send_trial(32'sd0, 32'sd0, 30'd9);
      send_trial(32'sh7fff_ffff, -32'sh8000_0000, 30'd10);
      drain();
      // no move, unbounded ellipse: the step limit ends the walk
      csr_write(CSR_INV_A_SQ, 32'h0);
      csr_write(CSR_INV_B_SQ, 32'h0);
      csr_write(CSR_TIME_STEP, 32'h0);
      csr_write(CSR_STEP_SIZE, 32'h0);
      csr_write(CSR_MAX_STEPS, 32'd20);
      send_trial(32'sd100, -32'sd100, 30'd11);
      send_trial(32'sh7fff_ffff, 32'sd0, 30'd12);
      drain();
      csr_write(CSR_MAX_STEPS, 32'd0);
      send_trial(32'sd0, 32'sd0, 30'd13);
      drain();
      // spare indexes must not touch any register
      csr_write(CSR_SPARE, 32'hffff_ffff);
      csr_write(CSR_TOP, 32'h0);
      csr_write(CSR_MAX_STEPS, 32'hff00_0001);
      csr_write(CSR_STEP_SIZE, 32'h4000_0000);
      csr_write(CSR_INV_A_SQ, RST_INV_A_SQ);
      csr_write(CSR_INV_B_SQ, RST_INV_B_SQ);
      csr_write(CSR_TIME_STEP, 32'h0400_0000);
      send_trial(32'sh1000_0000, 32'sd0, 30'd14);
      drain();
      // exit on a short limit: one step allowed, start outside the ellipse
      csr_write(CSR_MAX_STEPS, 32'd1);
      for (int i = 0; i < 6; i++) send_trial(32'sh1f00_0000, 32'sh0f00_0000, 30'(i));
      drain();
   endtask

   task automatic test_random;
      logic signed [31:0] sx, sy;
      for (int ph = 0; ph < 6; ph++) begin
         calm = (ph == 2);
         csr_write(CSR_INV_A_SQ, ($urandom_range(0, 5) == 0) ? $urandom
                                 : $urandom_range(32'h0800_0000, 32'h8000_0000));
         csr_write(CSR_INV_B_SQ, ($urandom_range(0, 5) == 0) ? $urandom
                                 : $urandom_range(32'h0800_0000, 32'h8000_0000));
         csr_write(CSR_TIME_STEP, ($urandom_range(0, 3) == 0) ? $urandom
                                  : $urandom_range(0, 32'h0400_0000));
         csr_write(CSR_STEP_SIZE, ($urandom_range(0, 4) == 0) ? $urandom
                                  : $urandom_range(32'h0800_0000, 32'h4000_0000));
         csr_write(CSR_MAX_STEPS, {$urandom_range(0, 255), 24'(0)}
                                  | $urandom_range(1, 200));
         for (int i = 0; i < 48; i++) begin
            if ($urandom_range(0, 4) == 0) begin
               sx = $urandom;
               sy = $urandom;
            end else begin
               sx = $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
               sy = $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
            end
            send_trial(sx, sy, 30'($urandom_range(0, 1000000000)));
         end
         drain();
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      walk_out_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         pop_wait = calm ? 0 : $urandom_range(0, 10);
         if (pending_walks.size() == 0) begin
            report("unexpected response", 32'd1, 32'd0);
         end else begin
            e = pending_walks.pop_front();
            if (rsp_weight !== e.weight) report("weight", rsp_weight, e.weight);
            if (rsp_steps_taken !== e.steps) report("steps_taken", rsp_steps_taken, e.steps);
            if (rsp_limit_hit !== e.hit) report("limit_hit", rsp_limit_hit, e.hit);
         end
      end
   end

   always @(negedge clock) begin
      if (pop_wait > 0) begin
         rsp_pop = 1'b0;
         pop_wait--;
      end else rsp_pop = !reset;
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("feynman_kac_walk_trial_tb NOT OK");
         $finish;
      end
   end

   initial begin
      m_inv_a = RST_INV_A_SQ;
      m_inv_b = RST_INV_B_SQ;
      m_h = RST_TIME_STEP;
      m_step = RST_STEP_SIZE;
      m_max = RST_MAX_STEPS;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_defaults();
      test_edges();
      test_random();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("feynman_kac_walk_trial_tb OK");
      end else begin
         $display("feynman_kac_walk_trial_tb NOT OK");
      end
      $finish;
   end
endmodule

[filelist.f]
hw/rtl/fkw_pkg.sv
hw/rtl/fkw_fifo.sv
hw/rtl/fkw_front.sv
hw/rtl/fkw_mul.sv
hw/rtl/fkw_walk.sv
hw/rtl/feynman_kac_walk_trial.sv
tb/sv/feynman_kac_walk_trial_tb.sv
